// File: hdl/bblru_pkg.sv
// Shared types and constants for the byte-budget LRU cache core.
`default_nettype none

package bblru_pkg;

    // Configuration port geometry and register indexes.
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 64;
    localparam int LIMIT_W  = 3;
    localparam int BUDGET_W = 36;

    localparam logic REG_ENTRY_LIMIT = 1'b0;
    localparam logic REG_BYTE_BUDGET = 1'b1;

    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 3'd4;
    localparam logic [BUDGET_W-1:0] BUDGET_RESET = 36'd134217728;

    // Result field widths.
    localparam int OUT_KEY_W = 32;
    localparam int OUT_CNT_W = 4;
    localparam int OUT_TOT_W = 36;
    localparam int SIZE_W    = 32;

    localparam logic KIND_EVICT   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [LIMIT_W-1:0]  entry_limit;
        logic [BUDGET_W-1:0] byte_budget;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOKUP,
        S_ROOM_RD,
        S_ROOM_EX,
        S_INSERT,
        S_TOUCH,
        S_TRIM_RD,
        S_TRIM_EX,
        S_SUMMARY
    } state_t;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic insert;
        logic touch;
        logic walk_read;
        logic walk_exec;
        logic summary;
    } dp_cmd_t;

    typedef struct packed {
        logic hit;
        logic full;
        logic trim_needed;
        logic exec_ok;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: hdl/bblru_cfg.sv
// Configuration register file behind the APB-style port.
`default_nettype none

module bblru_cfg
    import bblru_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic [LIMIT_W-1:0]  limit_reg;
    logic [BUDGET_W-1:0] budget_reg;
    logic                wr_en;
    logic                reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    // Registers sit on 8-byte boundaries, so bit 3 selects the register.
    assign reg_idx = paddr[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= LIMIT_RESET;
            budget_reg <= BUDGET_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_ENTRY_LIMIT: limit_reg  <= pwdata[LIMIT_W-1:0];
                REG_BYTE_BUDGET: budget_reg <= pwdata[BUDGET_W-1:0];
                default:         limit_reg  <= limit_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ENTRY_LIMIT: prdata = DATA_W'(limit_reg);
            REG_BYTE_BUDGET: prdata = DATA_W'(budget_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.entry_limit = limit_reg;
    assign cfg.byte_budget = budget_reg;

endmodule

`default_nettype wire

// File: hdl/bblru_ctrl.sv
// Sequencing state machine for lookup, insert or touch, eviction walk and summary.
`default_nettype none

module bblru_ctrl
    import bblru_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = S_ROOM_RD;
            end
            S_ROOM_RD:
            begin
                // A miss on a full store walks until one slot is free.
                if (stat.hit)
                begin
                    state_next = S_TOUCH;
                end
                else if (stat.full)
                begin
                    cmd.walk_read = 1'b1;
                    state_next    = S_ROOM_EX;
                end
                else
                begin
                    state_next = S_INSERT;
                end
            end
            S_ROOM_EX:
            begin
                if (stat.exec_ok)
                begin
                    cmd.walk_exec = 1'b1;
                    state_next    = S_ROOM_RD;
                end
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = S_TRIM_RD;
            end
            S_TOUCH:
            begin
                cmd.touch  = 1'b1;
                state_next = S_TRIM_RD;
            end
            S_TRIM_RD:
            begin
                if (stat.trim_needed)
                begin
                    cmd.walk_read = 1'b1;
                    state_next    = S_TRIM_EX;
                end
                else
                begin
                    state_next = S_SUMMARY;
                end
            end
            S_TRIM_EX:
            begin
                if (stat.exec_ok)
                begin
                    cmd.walk_exec = 1'b1;
                    state_next    = S_TRIM_RD;
                end
            end
            S_SUMMARY:
            begin
                if (stat.out_free)
                begin
                    cmd.summary = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/bblru_dp.sv
// Entry store, recency ranks, totals and the result register.
`default_nettype none

module bblru_dp
    import bblru_pkg::*;
#(
    parameter int MAX_ENTRIES = 8,
    parameter int KEY_BITS    = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dp_cmd_t              cmd,
    output dp_stat_t                  stat,
    input  wire cfg_t                 cfg,
    input  wire logic [OUT_KEY_W-1:0] key,
    input  wire logic [SIZE_W-1:0]    size_bytes,
    input  wire logic [OUT_KEY_W-1:0] pinned_key,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output logic                      kind,
    output logic      [OUT_KEY_W-1:0] key_out,
    output logic                      hit,
    output logic      [OUT_CNT_W-1:0] entry_count,
    output logic      [OUT_TOT_W-1:0] total_bytes,
    output logic                      last
);

    localparam int KW     = (KEY_BITS < OUT_KEY_W) ? KEY_BITS : OUT_KEY_W;
    localparam int SLOT_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int TOT_W  = SIZE_W + CNT_W;
    localparam int CMP_W  = (TOT_W > BUDGET_W) ? TOT_W : BUDGET_W;
    localparam int LIM_CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    // Per-entry stores; keys are compared in place like a small CAM.
    logic [KW-1:0]          keys_reg [MAX_ENTRIES];
    logic [SIZE_W-1:0]      size_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [MAX_ENTRIES-1:0] valid_next;
    logic [SLOT_W-1:0]      rank_reg  [MAX_ENTRIES];
    logic [SLOT_W-1:0]      rank_next [MAX_ENTRIES];
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [TOT_W-1:0]       total_reg;
    logic [TOT_W-1:0]       total_next;

    // Request being worked on.
    logic [OUT_KEY_W-1:0]   key_in_reg;
    logic [SIZE_W-1:0]      size_in_reg;
    logic [KW-1:0]          pinned_reg;
    logic                   hit_reg;
    logic [SLOT_W-1:0]      hit_slot_reg;
    logic [SLOT_W-1:0]      lru_slot_reg;
    logic [KW-1:0]          lru_key_reg;
    logic                   lru_pinned_reg;
    logic [SIZE_W-1:0]      size_rd_reg;

    // Result register.
    logic                   out_valid_reg;
    logic                   kind_reg;
    logic [OUT_KEY_W-1:0]   key_out_reg;
    logic                   hit_out_reg;
    logic [OUT_CNT_W-1:0]   count_out_reg;
    logic [OUT_TOT_W-1:0]   total_out_reg;
    logic                   last_reg;

    logic [MAX_ENTRIES-1:0] match_vec;
    logic [SLOT_W-1:0]      hit_idx;
    logic [SLOT_W-1:0]      lru_idx;
    logic [SLOT_W-1:0]      free_idx;
    logic [SLOT_W-1:0]      pivot_idx;
    logic [SLOT_W-1:0]      pivot_rank;
    logic [CNT_W-1:0]       count_dec;
    logic                   promote;
    logic                   load_evict;
    logic                   out_free;

    always_comb
    begin
        hit_idx  = '0;
        lru_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            match_vec[i] = valid_reg[i] && (keys_reg[i] == key_in_reg[KW-1:0]);
            if (match_vec[i])
            begin
                hit_idx = SLOT_W'(i);
            end
            if (valid_reg[i] && (rank_reg[i] == '0))
            begin
                lru_idx = SLOT_W'(i);
            end
        end
        // Lowest-numbered empty slot takes a new entry.
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = SLOT_W'(i);
            end
        end
    end

    assign pivot_idx  = cmd.touch ? hit_slot_reg : lru_slot_reg;
    assign pivot_rank = rank_reg[pivot_idx];
    assign count_dec  = count_reg - CNT_W'(1);
    assign promote    = cmd.touch || (cmd.walk_exec && lru_pinned_reg);
    assign load_evict = cmd.walk_exec && !lru_pinned_reg;
    assign out_free   = !out_valid_reg || out_ready;

    // Entries above the pivot close the gap it leaves; the pivot either moves
    // to the most recent end or leaves the store.
    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        count_next = count_reg;
        total_next = total_reg;
        if (cmd.insert)
        begin
            valid_next[free_idx] = 1'b1;
            rank_next[free_idx]  = count_reg[SLOT_W-1:0];
            count_next           = count_reg + CNT_W'(1);
            total_next           = total_reg + TOT_W'(size_in_reg);
        end
        if (cmd.touch || cmd.walk_exec)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                if (valid_reg[i] && (rank_reg[i] > pivot_rank))
                begin
                    rank_next[i] = rank_reg[i] - SLOT_W'(1);
                end
            end
            if (promote)
            begin
                rank_next[pivot_idx] = count_dec[SLOT_W-1:0];
            end
            else
            begin
                valid_next[pivot_idx] = 1'b0;
                rank_next[pivot_idx]  = '0;
                count_next            = count_dec;
                total_next            = total_reg - TOT_W'(size_rd_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            total_reg <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            total_reg <= total_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            keys_reg[free_idx] <= key_in_reg[KW-1:0];
            size_mem[free_idx] <= size_in_reg;
        end
        if (cmd.walk_read)
        begin
            size_rd_reg <= size_mem[lru_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            key_in_reg  <= key;
            size_in_reg <= size_bytes;
            pinned_reg  <= pinned_key[KW-1:0];
        end
        if (cmd.lookup)
        begin
            hit_reg      <= |match_vec;
            hit_slot_reg <= hit_idx;
        end
        if (cmd.walk_read)
        begin
            lru_slot_reg   <= lru_idx;
            lru_key_reg    <= keys_reg[lru_idx];
            lru_pinned_reg <= (keys_reg[lru_idx] == pinned_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_evict || cmd.summary)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_evict)
        begin
            kind_reg      <= KIND_EVICT;
            key_out_reg   <= OUT_KEY_W'(lru_key_reg);
            hit_out_reg   <= 1'b0;
            count_out_reg <= '0;
            total_out_reg <= '0;
            last_reg      <= 1'b0;
        end
        else if (cmd.summary)
        begin
            kind_reg      <= KIND_SUMMARY;
            key_out_reg   <= key_in_reg;
            hit_out_reg   <= hit_reg;
            count_out_reg <= OUT_CNT_W'(count_reg);
            total_out_reg <= OUT_TOT_W'(total_reg);
            last_reg      <= 1'b1;
        end
    end

    assign stat.hit         = hit_reg;
    assign stat.full        = (count_reg >= CNT_W'(MAX_ENTRIES));
    // A zero limit behaves as one because at least one entry always stays.
    assign stat.trim_needed = ((LIM_CMP_W'(count_reg) > LIM_CMP_W'(cfg.entry_limit))
                               || (CMP_W'(total_reg) > CMP_W'(cfg.byte_budget)))
                              && (count_reg > CNT_W'(1));
    assign stat.exec_ok     = lru_pinned_reg || out_free;
    assign stat.out_free    = out_free;

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign key_out     = key_out_reg;
    assign hit         = hit_out_reg;
    assign entry_count = count_out_reg;
    assign total_bytes = total_out_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

// File: hdl/byte_budget_lru_cache_core.sv
// Top level of the byte-budget LRU cache: config registers, controller, datapath.
//
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    key, size_bytes, pinned_key
// out       output     out_valid/out_ready  kind, key_out, hit, entry_count,
//                                           total_bytes, last
// cfg       input      APB psel/penable     paddr, pwdata, prdata
//
// One request at a time: with no walk it passes lookup, room check, insert or touch,
// trim check and summary. Each walk step is a rank search with size read, then an
// evict or move; trimming takes at most one step per stored entry, after any steps
// that free a slot for a miss on a full store.
// Reset clears valid flags, ranks, entry count and byte total; no clearing pass.
// A full result register stalls the walk; in_ready returns once the summary is loaded.
`default_nettype none

module byte_budget_lru_cache_core
    import bblru_pkg::*;
#(
    parameter int MAX_ENTRIES = 8,
    parameter int KEY_BITS    = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_W-1:0]    paddr,
    input  wire logic [DATA_W-1:0]    pwdata,
    output logic      [DATA_W-1:0]    prdata,
    output logic                      pready,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [OUT_KEY_W-1:0] key,
    input  wire logic [SIZE_W-1:0]    size_bytes,
    input  wire logic [OUT_KEY_W-1:0] pinned_key,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      kind,
    output logic      [OUT_KEY_W-1:0] key_out,
    output logic                      hit,
    output logic      [OUT_CNT_W-1:0] entry_count,
    output logic      [OUT_TOT_W-1:0] total_bytes,
    output logic                      last
);

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    bblru_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bblru_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bblru_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg         (cfg),
        .key         (key),
        .size_bytes  (size_bytes),
        .pinned_key  (pinned_key),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .kind        (kind),
        .key_out     (key_out),
        .hit         (hit),
        .entry_count (entry_count),
        .total_bytes (total_bytes),
        .last        (last)
    );

endmodule

`default_nettype wire
